// ===== hw/rtl/aes128_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aes128_pkg
// Shared constants and round transforms for the AES-128 encryption pipeline.
// ----------------------------------------------------------------------------
package aes128_pkg;

	localparam int unsigned BLK_W = 128;
	localparam int unsigned HALF_W = 64;
	localparam int unsigned NUM_ROUNDS = 10;

	typedef logic [BLK_W-1:0] block_t;
	typedef logic [7:0] byte_t;

	localparam logic CFG_KEY_HIGH = 1'b0;
	localparam logic CFG_KEY_LOW = 1'b1;

	localparam byte_t SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam byte_t RCON [NUM_ROUNDS] = '{
		8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
	};

	function automatic byte_t get_byte(input block_t b, input int unsigned n);
		return b[8*(15-n) +: 8];
	endfunction

	function automatic byte_t xtime(input byte_t x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic block_t sub_shift(input block_t b);
		block_t o;
		o = '0;
		for (int unsigned c = 0; c < 4; c++) begin
			for (int unsigned r = 0; r < 4; r++) begin
				o[8*(15-(r+4*c)) +: 8] = SBOX[get_byte(b, r + 4*((c + r) % 4))];
			end
		end
		return o;
	endfunction

	function automatic block_t mix_cols(input block_t b);
		block_t o;
		byte_t a0, a1, a2, a3;
		o = '0;
		for (int unsigned c = 0; c < 4; c++) begin
			a0 = get_byte(b, 4*c);
			a1 = get_byte(b, 4*c + 1);
			a2 = get_byte(b, 4*c + 2);
			a3 = get_byte(b, 4*c + 3);
			o[8*(15-4*c) +: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
			o[8*(14-4*c) +: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
			o[8*(13-4*c) +: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
			o[8*(12-4*c) +: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
		end
		return o;
	endfunction

	function automatic block_t next_key(input block_t k, input byte_t rc);
		logic [31:0] t, w0, w1, w2, w3;
		t = {SBOX[get_byte(k, 13)] ^ rc, SBOX[get_byte(k, 14)],
			SBOX[get_byte(k, 15)], SBOX[get_byte(k, 12)]};
		w0 = k[127:96] ^ t;
		w1 = k[95:64] ^ w0;
		w2 = k[63:32] ^ w1;
		w3 = k[31:0] ^ w2;
		return {w0, w1, w2, w3};
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/aes128_block_encrypt_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aes128_block_encrypt_top
// AES-128 encryption, eleven-stage round pipeline.
//
// The input channel takes a plaintext word as two 64-bit halves; the output
// channel returns the ciphertext word the same way. Both channels use valid
// and stall. The key is written via cfg_wr/cfg_index/cfg_data (index 0 is
// the high key half, index 1 the low half); the user must write it only
// while the pipeline is empty; the block does not enforce it. Each round
// stage derives its round key from the previous; key writes need no expansion.
// An accepted word passes through eleven register stages: initial key add,
// then ten rounds. The pipeline takes one word per cycle while in_stall is low.
// Reset clears all valid bits and both key halves to zero.
// When the receiver stalls, the result holds and each stage still fills if
// empty; input stall rises only once every stage is occupied.
// ----------------------------------------------------------------------------
module aes128_block_encrypt_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr,
	input  wire logic        cfg_index,
	input  wire logic [63:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [63:0] plain_high,
	input  wire logic [63:0] plain_low,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [63:0]      cipher_high,
	output logic [63:0]      cipher_low
);
	import aes128_pkg::*;

	logic [HALF_W-1:0] key_high_q;
	logic [HALF_W-1:0] key_low_q;

	logic v_s1;
	block_t state_s1;
	block_t key_s1;

	logic v_s [NUM_ROUNDS+1];
	block_t st_s [NUM_ROUNDS+1];
	block_t kx_s [NUM_ROUNDS+1];
	logic adv [NUM_ROUNDS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				CFG_KEY_HIGH: key_high_q <= cfg_data;
				CFG_KEY_LOW: key_low_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// advance a stage when it is empty or the next one advances
	always_comb begin
		adv[NUM_ROUNDS] = !v_s[NUM_ROUNDS] || !out_stall;
		for (int i = NUM_ROUNDS - 1; i >= 0; i--) begin
			adv[i] = !v_s[i] || adv[i+1];
		end
	end

	assign in_stall = !adv[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv[0]) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			state_s1 <= {plain_high, plain_low} ^ {key_high_q, key_low_q};
			key_s1 <= {key_high_q, key_low_q};
		end
	end

	assign v_s[0] = v_s1;
	assign st_s[0] = state_s1;
	assign kx_s[0] = key_s1;

	for (genvar g = 0; g < NUM_ROUNDS; g++) begin : g_round
		aes128_round u_round (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv[g+1]),
			.v_in     (v_s[g]),
			.state_in (st_s[g]),
			.key_in   (kx_s[g]),
			.rcon     (RCON[g]),
			.last     (1'(g == NUM_ROUNDS - 1)),
			.v_s      (v_s[g+1]),
			.state_s  (st_s[g+1]),
			.key_s    (kx_s[g+1])
		);
	end

	assign out_valid = v_s[NUM_ROUNDS];
	assign cipher_high = st_s[NUM_ROUNDS][BLK_W-1:HALF_W];
	assign cipher_low = st_s[NUM_ROUNDS][HALF_W-1:0];

endmodule
`default_nettype wire

// ===== hw/rtl/aes128_round.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aes128_round
// One registered cipher round with its round key derived alongside.
// ----------------------------------------------------------------------------
module aes128_round (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              adv,
	input  wire logic              v_in,
	input  wire aes128_pkg::block_t state_in,
	input  wire aes128_pkg::block_t key_in,
	input  wire aes128_pkg::byte_t  rcon,
	input  wire logic              last,
	output logic                   v_s,
	output aes128_pkg::block_t     state_s,
	output aes128_pkg::block_t     key_s
);
	import aes128_pkg::*;

	block_t key_nx;
	block_t sb;
	block_t mx;

	always_comb begin
		key_nx = next_key(key_in, rcon);
		sb = sub_shift(state_in);
		mx = last ? sb : mix_cols(sb);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= 1'b0;
		end else if (adv) begin
			v_s <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			state_s <= mx ^ key_nx;
			key_s <= key_nx;
		end
	end

endmodule
`default_nettype wire

// ===== tb/tb_aes128_block_encrypt_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_aes128_block_encrypt_top
// Self-checking bench for the AES-128 encryption pipeline. A behavioural
// cipher predicts each ciphertext word from the plaintext and the current key;
// a scoreboard matches words in order while both channels idle and stall at
// random through several key settings.
// ----------------------------------------------------------------------------
module tb_aes128_block_encrypt_top;
	import aes128_pkg::*;

	localparam int PIPE_DEPTH = 11;
	localparam int RANDOM_WORDS = 1700;

	typedef struct packed {
		logic [63:0] hi;
		logic [63:0] lo;
	} half_pair_t;

	logic clk;
	logic arst_n;
	logic cfg_wr;
	logic cfg_index;
	logic [63:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic [63:0] plain_high;
	logic [63:0] plain_low;
	logic out_valid;
	logic out_stall;
	logic [63:0] cipher_high;
	logic [63:0] cipher_low;

	logic [63:0] key_hi_q;
	logic [63:0] key_lo_q;
	int send_idle_pct;
	int recv_stall_pct;
	int words_sent;
	int keys_used;

	// ------------------------------------------------------------------
	// AES-128 encryption of one block under the current key
	// ------------------------------------------------------------------
	function automatic logic [7:0] gf_double(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic half_pair_t aes_encrypt(input logic [63:0] key_hi,
			input logic [63:0] key_lo, input logic [63:0] pt_hi,
			input logic [63:0] pt_lo);
		logic [7:0] rk [176];
		logic [7:0] st [16];
		logic [7:0] old [16];
		logic [7:0] tw [4];
		logic [7:0] first, a0, a1, a2, a3;
		logic [7:0] rcon;
		half_pair_t res;
		for (int n = 0; n < 8; n++) begin
			rk[n] = key_hi[56-8*n +: 8];
			rk[n+8] = key_lo[56-8*n +: 8];
			st[n] = pt_hi[56-8*n +: 8];
			st[n+8] = pt_lo[56-8*n +: 8];
		end
		rcon = 8'h01;
		for (int i = 4; i < 44; i++) begin
			for (int r = 0; r < 4; r++) tw[r] = rk[4*(i-1)+r];
			if (i % 4 == 0) begin
				first = tw[0];
				tw[0] = SBOX[tw[1]] ^ rcon;
				tw[1] = SBOX[tw[2]];
				tw[2] = SBOX[tw[3]];
				tw[3] = SBOX[first];
				rcon = gf_double(rcon);
			end
			for (int r = 0; r < 4; r++) rk[4*i+r] = tw[r] ^ rk[4*(i-4)+r];
		end
		for (int n = 0; n < 16; n++) st[n] ^= rk[n];
		for (int rnd = 1; rnd <= 10; rnd++) begin
			old = st;
			for (int c = 0; c < 4; c++)
				for (int r = 0; r < 4; r++)
					st[r+4*c] = SBOX[old[r + 4*((c+r)%4)]];
			if (rnd < 10) begin
				for (int c = 0; c < 4; c++) begin
					a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
					st[4*c]   = gf_double(a0) ^ gf_double(a1) ^ a1 ^ a2 ^ a3;
					st[4*c+1] = a0 ^ gf_double(a1) ^ gf_double(a2) ^ a2 ^ a3;
					st[4*c+2] = a0 ^ a1 ^ gf_double(a2) ^ gf_double(a3) ^ a3;
					st[4*c+3] = gf_double(a0) ^ a0 ^ a1 ^ a2 ^ gf_double(a3);
				end
			end
			for (int n = 0; n < 16; n++) st[n] ^= rk[16*rnd+n];
		end
		for (int n = 0; n < 8; n++) begin
			res.hi[56-8*n +: 8] = st[n];
			res.lo[56-8*n +: 8] = st[n+8];
		end
		return res;
	endfunction

	class cipher_scoreboard;
		half_pair_t pending[$];
		int errors;
		int matched;

		function new();
			errors = 0;
			matched = 0;
		endfunction

		function void note_plain(logic [63:0] khi, logic [63:0] klo,
				logic [63:0] phi, logic [63:0] plo);
			pending.push_back(aes_encrypt(khi, klo, phi, plo));
		endfunction

		function void check_cipher(logic [63:0] chi, logic [63:0] clo);
			half_pair_t exp_w;
			if (pending.size() == 0) begin
				$display("%0t: unexpected word expected none actual %h %h",
					$time, chi, clo);
				errors++;
				return;
			end
			exp_w = pending.pop_front();
			if (chi !== exp_w.hi) begin
				$display("%0t: cipher_high expected %h actual %h", $time, exp_w.hi, chi);
				errors++;
			end
			if (clo !== exp_w.lo) begin
				$display("%0t: cipher_low expected %h actual %h", $time, exp_w.lo, clo);
				errors++;
			end
			matched++;
		endfunction
	endclass

	cipher_scoreboard sb;

	aes128_block_encrypt_top u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr(cfg_wr), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.plain_high(plain_high), .plain_low(plain_low),
		.out_valid(out_valid), .out_stall(out_stall),
		.cipher_high(cipher_high), .cipher_low(cipher_low)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.note_plain(key_hi_q, key_lo_q, plain_high, plain_low);
		if (arst_n && out_valid && !out_stall)
			sb.check_cipher(cipher_high, cipher_low);
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [63:0] pattern64();
		case ($urandom_range(5))
			0: return '0;
			1: return '1;
			2: return 64'h1 << $urandom_range(63);
			3: return ~(64'h1 << $urandom_range(63));
			default: return rand64();
		endcase
	endfunction

	task automatic write_key(input logic [63:0] khi, input logic [63:0] klo);
		@(negedge clk);
		cfg_wr <= 1'b1;
		cfg_index <= CFG_KEY_HIGH;
		cfg_data <= khi;
		@(negedge clk);
		cfg_index <= CFG_KEY_LOW;
		cfg_data <= klo;
		@(negedge clk);
		cfg_wr <= 1'b0;
		key_hi_q = khi;
		key_lo_q = klo;
		keys_used++;
	endtask

	// hold the word until accepted; the next word's idle gap or drain drops valid
	task automatic send_word(input logic [63:0] phi, input logic [63:0] plo);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		plain_high <= phi;
		plain_low <= plo;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
		words_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (PIPE_DEPTH + 4) @(negedge clk);
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		cfg_wr = 1'b0;
		cfg_index = CFG_KEY_HIGH;
		cfg_data = '0;
		in_valid = 1'b0;
		plain_high = '0;
		plain_low = '0;
		key_hi_q = '0;
		key_lo_q = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		words_sent = 0;
		keys_used = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset key, then the FIPS-197 example keys and the extremes
		send_word('0, '0);
		send_word('1, '1);
		drain();
		write_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
		send_word(64'h0011223344556677, 64'h8899aabbccddeeff);
		send_word('0, '0);
		send_word('1, '1);
		drain();
		write_key('1, '1);
		send_word('0, '0);
		send_word('1, '1);
		send_word(64'h8000000000000000, 64'h0000000000000001);
		drain();
		write_key(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c);
		send_word(64'h3243f6a8885a308d, 64'h313198a2e0370734);
		for (int i = 0; i < 8; i++) send_word(pattern64(), pattern64());
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
				default: begin send_idle_pct = 14; recv_stall_pct = 14; end
			endcase
			if (ph == 4) write_key('0, '0);
			else if (ph == 7) write_key('1, '1);
			else write_key(pattern64(), pattern64());
			for (int i = 0; i < RANDOM_WORDS / 8; i++)
				send_word(pattern64(), pattern64());
			drain();
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
		drain();

		$display("Encrypted %0d words under %0d keys, %0d results checked.",
			words_sent, keys_used, sb.matched);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("tb_aes128_block_encrypt_top passed");
		end else begin
			$display("tb_aes128_block_encrypt_top failed");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("tb_aes128_block_encrypt_top failed");
		$finish;
	end

endmodule

// ===== aes128_block_encrypt_top.f =====
hw/rtl/aes128_pkg.sv
hw/rtl/aes128_round.sv
hw/rtl/aes128_block_encrypt_top.sv
tb/tb_aes128_block_encrypt_top.sv
